// File: src/plmp_pkg.sv
// Package for the periodic local minimum picker.
// Holds field widths, result limits, register indexes and the sequencer state type.
// No dependencies.
package plmp_pkg;

  localparam int unsigned COST_W           = 32;
  localparam int unsigned SKIP_W           = 10;
  localparam int unsigned FRAME_W          = 11;
  localparam int unsigned RESULT_LIMIT     = 48;
  localparam int unsigned EMIT_W           = 6;
  localparam int unsigned NEIGHBOUR_SPAN   = 2;
  localparam int unsigned FIRST_SCAN_INDEX = 3;
  localparam int unsigned WINDOW_LEN       = 5;
  localparam int unsigned CMP_IDX_W        = 2;

  localparam logic [FRAME_W-1:0] REFERENCE_RESET = FRAME_W'(2);

  typedef enum logic [0:0] {
    CFG_SKIP_COUNT      = 1'b0,
    CFG_REFERENCE_FRAME = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHECK,
    ST_ERROR,
    ST_READ,
    ST_SHIFT,
    ST_COMPARE,
    ST_DECIDE,
    ST_FLUSH
  } state_e;

endpackage

// File: src/plmp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module plmp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/periodic_local_minimum_picker.sv
// Periodic local minimum picker: loads a cost profile, then emits selected frame numbers.
// Loading takes one cycle per sample; the last sample starts selection with input stalled:
// a check, window priming, a read, shift and decide step per profile position, a compare
// with each of four neighbours per candidate (one shared comparator), then a flush.
// Results leave through an output register; selection waits on it when stalled.
// Reset: control, counters, config reset; window, result data, sample store undefined.
module periodic_local_minimum_picker
  import plmp_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [COST_W-1:0] cost_value_i,
  input  logic                last_sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [FRAME_W-1:0]  frame_number_o,
  output logic                end_of_list_o,
  output logic                range_error_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  cfg_reg_e            cfg_index_i,
  input  logic [FRAME_W-1:0]  cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned ADR_W = CNT_W + 1;
  localparam int unsigned DW    = (CNT_W + 1 > FRAME_W + 1) ? CNT_W + 1 : FRAME_W + 1;
  localparam int unsigned SW    = ((CNT_W > SKIP_W) ? CNT_W : SKIP_W) + 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

  state_e state_q, state_d;

  logic [SKIP_W-1:0]  skip_q;
  logic [FRAME_W-1:0] ref_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [CNT_W-1:0]   r_q, r_d;
  logic [ADR_W-1:0]   rd_addr_q, rd_addr_d;
  logic [CNT_W-1:0]   j_q, j_d;
  logic signed [COST_W-1:0] win_q [WINDOW_LEN];
  logic signed [COST_W-1:0] win_d [WINDOW_LEN];
  logic [CMP_IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic               is_min_q, is_min_d;
  logic               pend_v_q, pend_v_d;
  logic [CNT_W-1:0]   pend_idx_q, pend_idx_d;
  logic [EMIT_W-1:0]  emit_cnt_q, emit_cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [FRAME_W-1:0] out_frame_q, out_frame_d;
  logic               out_eol_q, out_eol_d;
  logic               out_err_q, out_err_d;

  logic               in_accept;
  logic               store_full;
  logic               ram_we, ram_re;
  logic [COST_W-1:0]  ram_rdata;
  logic               out_free;
  logic               out_load;

  logic [DW-1:0]      diff;
  logic               range_err;
  logic [CNT_W-1:0]   j_new;
  logic               cand;
  logic               sel;
  logic               last_pos;
  logic               limit_hit;
  logic signed [COST_W-1:0] nbr;
  logic               lt;
  logic [SW-1:0]      frame_sum;

  plmp_ram #(
    .WIDTH (COST_W),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (cost_value_i),
    .re_i    (ram_re),
    .raddr_i (rd_addr_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != ST_LOAD);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign store_full  = (count_q >= MAX_CNT);
  assign ram_we      = in_accept && !store_full;
  assign ram_re      = (state_q == ST_READ) && (rd_addr_q < {1'b0, n_q});
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign diff = DW'({1'b0, ref_q}) - DW'({1'b0, skip_q});
  assign range_err = diff[DW-1] || (diff < DW'(NEIGHBOUR_SPAN)) || (n_q < CNT_W'(3)) ||
                     (diff > DW'(n_q - CNT_W'(3)));

  assign j_new = CNT_W'(rd_addr_q - ADR_W'(NEIGHBOUR_SPAN));
  assign cand  = (j_new >= CNT_W'(NEIGHBOUR_SPAN)) &&
                 ((ADR_W'(j_new) + ADR_W'(NEIGHBOUR_SPAN)) < ADR_W'(n_q)) &&
                 ((j_new >= CNT_W'(FIRST_SCAN_INDEX)) || (j_new == r_q));

  assign last_pos  = (j_q == n_q - CNT_W'(1));
  assign sel       = (j_q == '0) || (j_q == r_q) || last_pos || is_min_q;
  assign limit_hit = (emit_cnt_q == EMIT_W'(RESULT_LIMIT - 1));
  assign frame_sum = SW'(pend_idx_q) + SW'(skip_q);

  always_comb begin
    unique case (cmp_idx_q)
      2'd0:    nbr = win_q[0];
      2'd1:    nbr = win_q[1];
      2'd2:    nbr = win_q[3];
      default: nbr = win_q[4];
    endcase
  end

  assign lt = (win_q[2] < nbr);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_accept && last_sample_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = range_err ? ST_ERROR : ST_READ;
      end
      ST_ERROR: begin
        if (out_free) begin
          state_d = ST_LOAD;
        end
      end
      ST_READ: begin
        state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (rd_addr_q < ADR_W'(NEIGHBOUR_SPAN)) begin
          state_d = ST_READ;
        end else if (cand) begin
          state_d = ST_COMPARE;
        end else begin
          state_d = ST_DECIDE;
        end
      end
      ST_COMPARE: begin
        if (cmp_idx_q == '1) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sel && pend_v_q) begin
          if (out_free) begin
            if (limit_hit) begin
              state_d = ST_LOAD;
            end else begin
              state_d = last_pos ? ST_FLUSH : ST_READ;
            end
          end
        end else begin
          state_d = last_pos ? ST_FLUSH : ST_READ;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d     = count_q;
    n_d         = n_q;
    r_d         = r_q;
    rd_addr_d   = rd_addr_q;
    j_d         = j_q;
    win_d       = win_q;
    cmp_idx_d   = cmp_idx_q;
    is_min_d    = is_min_q;
    pend_v_d    = pend_v_q;
    pend_idx_d  = pend_idx_q;
    emit_cnt_d  = emit_cnt_q;
    out_load    = 1'b0;
    out_frame_d = out_frame_q;
    out_eol_d   = out_eol_q;
    out_err_d   = out_err_q;

    unique case (state_q)
      ST_LOAD: begin
        if (in_accept) begin
          if (last_sample_i) begin
            n_d     = store_full ? count_q : count_q + CNT_W'(1);
            count_d = '0;
          end else if (!store_full) begin
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      ST_CHECK: begin
        r_d        = CNT_W'(diff);
        rd_addr_d  = '0;
        pend_v_d   = 1'b0;
        emit_cnt_d = '0;
      end
      ST_ERROR: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_frame_d = '0;
          out_eol_d   = 1'b1;
          out_err_d   = 1'b1;
        end
      end
      ST_READ: begin
      end
      ST_SHIFT: begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[WINDOW_LEN-1] = ram_rdata;
        rd_addr_d = rd_addr_q + ADR_W'(1);
        j_d       = j_new;
        cmp_idx_d = '0;
        is_min_d  = cand;
      end
      ST_COMPARE: begin
        is_min_d  = is_min_q && lt;
        cmp_idx_d = cmp_idx_q + CMP_IDX_W'(1);
      end
      ST_DECIDE: begin
        if (sel) begin
          if (!pend_v_q) begin
            pend_v_d   = 1'b1;
            pend_idx_d = j_q;
          end else if (out_free) begin
            out_load    = 1'b1;
            out_frame_d = frame_sum[FRAME_W-1:0];
            out_eol_d   = limit_hit;
            out_err_d   = 1'b0;
            emit_cnt_d  = emit_cnt_q + EMIT_W'(1);
            pend_idx_d  = j_q;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_frame_d = frame_sum[FRAME_W-1:0];
          out_eol_d   = 1'b1;
          out_err_d   = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      skip_q      <= '0;
      ref_q       <= REFERENCE_RESET;
      count_q     <= '0;
      n_q         <= '0;
      rd_addr_q   <= '0;
      j_q         <= '0;
      cmp_idx_q   <= '0;
      is_min_q    <= 1'b0;
      pend_v_q    <= 1'b0;
      emit_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      n_q         <= n_d;
      rd_addr_q   <= rd_addr_d;
      j_q         <= j_d;
      cmp_idx_q   <= cmp_idx_d;
      is_min_q    <= is_min_d;
      pend_v_q    <= pend_v_d;
      emit_cnt_q  <= emit_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_SKIP_COUNT) begin
          skip_q <= cfg_data_i[SKIP_W-1:0];
        end else begin
          ref_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_q         <= r_d;
    win_q       <= win_d;
    pend_idx_q  <= pend_idx_d;
    out_frame_q <= out_frame_d;
    out_eol_q   <= out_eol_d;
    out_err_q   <= out_err_d;
  end

  assign out_valid_o    = out_valid_q;
  assign frame_number_o = out_frame_q;
  assign end_of_list_o  = out_eol_q;
  assign range_error_o  = out_err_q;

  a_last_starts_check : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && last_sample_i |=> state_q == ST_CHECK)
    else $error("last sample did not start selection");

  a_error_ends_list : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> end_of_list_o)
    else $error("range error result without end of list");

  a_emit_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_cnt_q <= EMIT_W'(RESULT_LIMIT))
    else $error("emitted more results than allowed");

  a_no_load_while_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !out_load)
    else $error("output register overwritten while stalled");

endmodule

// File: bench/tb_periodic_local_minimum_picker.sv
// Self-checking bench for periodic_local_minimum_picker: loads cost profiles and checks every
// selected frame against an in-bench prediction, under random idle and stall bursts.
// Depends on plmp_pkg and the picker RTL.
`timescale 1ns / 1ps

module tb_periodic_local_minimum_picker;
  import plmp_pkg::*;

  localparam int DEPTH       = 128;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic signed [COST_W-1:0] cost;
    logic                     last;
  } cost_item_t;

  typedef struct {
    logic [FRAME_W-1:0] frame;
    logic               eol;
    logic               err;
  } frame_result_t;

  typedef enum int {
    PROFILE_VALLEYS,
    PROFILE_NOISE,
    PROFILE_TIES,
    PROFILE_EXTREMES
  } profile_shape_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [COST_W-1:0] cost_value_i = '0;
  logic last_sample_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [FRAME_W-1:0] frame_number_o;
  logic end_of_list_o;
  logic range_error_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  cfg_reg_e cfg_index_i = CFG_SKIP_COUNT;
  logic [FRAME_W-1:0] cfg_data_i = '0;

  logic signed [COST_W-1:0] cost_store [DEPTH];
  int                       cost_count = 0;
  logic [SKIP_W-1:0]        skip_cfg = '0;
  logic [FRAME_W-1:0]       reference_cfg = REFERENCE_RESET;

  cost_item_t    cost_queue [$];
  frame_result_t frames_due [$];
  cost_item_t    next_cost;
  frame_result_t got_frame;
  frame_result_t want_frame;

  int  items_queued = 0;
  int  items_accepted = 0;
  int  cfg_writes = 0;
  int  errors = 0;
  int  cycles = 0;
  int  send_gap = 0;
  int  stall_gap = 0;
  int  hold_left = 0;
  bit  hold_armed = 1'b0;
  bit  hold_done = 1'b0;
  bit  idle_on = 1'b1;
  logic in_taken = 1'b0;

  periodic_local_minimum_picker #(
    .MAX_SAMPLES(DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cost_value_i  (cost_value_i),
    .last_sample_i (last_sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .frame_number_o(frame_number_o),
    .end_of_list_o (end_of_list_o),
    .range_error_o (range_error_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit is_dip(int j);
    logic signed [COST_W-1:0] c;
    c = cost_store[j];
    return c < cost_store[j-1] && c < cost_store[j-2] &&
           c < cost_store[j+1] && c < cost_store[j+2];
  endfunction

  function automatic void take_cost(logic signed [COST_W-1:0] cost, logic last);
    int            n;
    int            r;
    int            j;
    int            picked_total;
    int            sent;
    bit            picked [DEPTH];
    frame_result_t res;
    if (cost_count < DEPTH) begin
      cost_store[cost_count] = cost;
      cost_count++;
    end
    if (!last) return;
    n = cost_count;
    cost_count = 0;
    r = int'(reference_cfg) - int'(skip_cfg);
    if (r < 2 || n < 3 || r > n - 3) begin
      res.frame = '0;
      res.eol = 1'b1;
      res.err = 1'b1;
      frames_due.insert(frames_due.size(), res);
      return;
    end
    picked = '{default: 1'b0};
    picked[0] = 1'b1;
    picked[r] = 1'b1;
    picked[n-1] = 1'b1;
    for (j = 2; j + 2 < n; j++) begin
      if ((j >= 3 || j == r) && is_dip(j)) picked[j] = 1'b1;
    end
    picked_total = 0;
    for (j = 0; j < n; j++) begin
      if (picked[j]) picked_total++;
    end
    if (picked_total > RESULT_LIMIT) picked_total = RESULT_LIMIT;
    sent = 0;
    for (j = 0; j < n && sent < picked_total; j++) begin
      if (picked[j]) begin
        res.frame = FRAME_W'(j + int'(skip_cfg));
        res.eol = (sent + 1 == picked_total);
        res.err = 1'b0;
        frames_due.insert(frames_due.size(), res);
        sent++;
      end
    end
  endfunction

  function automatic void report_error(string what, frame_result_t want, frame_result_t got);
    errors++;
    if (errors <= 10) begin
      $display("%s: expected frame %0d eol %0b err %0b, got frame %0d eol %0b err %0b",
               what, want.frame, want.eol, want.err, got.frame, got.eol, got.err);
    end
  endfunction

  function automatic logic signed [COST_W-1:0] cost_for(profile_shape_e shape, int k);
    case (shape)
      PROFILE_VALLEYS: begin
        if (k % 3 == 0) return COST_W'($urandom_range(0, 999)) - 500;
        return COST_W'($urandom_range(2000, 9999));
      end
      PROFILE_TIES: return COST_W'($urandom_range(0, 3));
      PROFILE_EXTREMES: begin
        case ($urandom_range(0, 5))
          0: return 32'sh8000_0000;
          1: return 32'sh8000_0001;
          2: return 32'sh7FFF_FFFF;
          3: return 32'sh7FFF_FFFE;
          4: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // sample transfers, run the prediction and check results
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_periodic_local_minimum_picker: done, errors");
      $finish;
    end else if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        take_cost(cost_value_i, last_sample_i);
        items_accepted++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SKIP_COUNT:      skip_cfg = cfg_data_i[SKIP_W-1:0];
          CFG_REFERENCE_FRAME: reference_cfg = cfg_data_i;
          default: ;
        endcase
        cfg_writes++;
      end
      if (out_valid_o && !out_stall_i) begin
        got_frame.frame = frame_number_o;
        got_frame.eol = end_of_list_o;
        got_frame.err = range_error_o;
        if (frames_due.size() == 0) begin
          want_frame = '{frame: '0, eol: 1'b0, err: 1'b0};
          report_error("result with nothing due", want_frame, got_frame);
        end else begin
          want_frame = frames_due.pop_front();
          if (got_frame.frame !== want_frame.frame || got_frame.eol !== want_frame.eol ||
              got_frame.err !== want_frame.err) begin
            report_error("result mismatch", want_frame, got_frame);
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (cost_queue.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 14);
        in_valid_i <= 1'b0;
      end else begin
        next_cost = cost_queue.pop_front();
        in_valid_i <= 1'b1;
        cost_value_i <= next_cost.cost;
        last_sample_i <= next_cost.last;
      end
    end
  end

  // hold off the output once for a long stretch so the block backs up
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_armed && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if (stall_gap > 0) begin
      stall_gap--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_gap = $urandom_range(0, 14);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic push_cost(logic signed [COST_W-1:0] cost, logic last);
    cost_queue.insert(cost_queue.size(), cost_item_t'{cost: cost, last: last});
    items_queued++;
  endtask

  task automatic queue_profile(int n, profile_shape_e shape);
    int k;
    for (k = 0; k < n; k++) push_cost(cost_for(shape, k), k == n - 1);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [FRAME_W-1:0] value);
    int seen;
    seen = cfg_writes;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(negedge clk_i); while (cfg_writes == seen);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (items_accepted != items_queued || frames_due.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  initial begin
    int n;
    int stored;
    int r;
    int lo;
    int hi;
    int skip;
    int reps;
    int k;
    int phase;
    int directed_items;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(CFG_SKIP_COUNT, '0);
    write_reg(CFG_REFERENCE_FRAME, FRAME_W'(2));
    // reference at index 2 is itself a dip and must come out once
    push_cost(5, 0); push_cost(4, 0); push_cost(-1, 0); push_cost(3, 0);
    push_cost(6, 0); push_cost(2, 0); push_cost(9, 1);
    wait_drained();
    push_cost(1, 0); push_cost(2, 0); push_cost(0, 1);
    wait_drained();

    write_reg(CFG_SKIP_COUNT, FRAME_W'(1023));
    write_reg(CFG_REFERENCE_FRAME, FRAME_W'(1027));
    push_cost(32'sh7FFF_FFFF, 0); push_cost(32'sh8000_0000, 0); push_cost(32'sh7FFF_FFFF, 0);
    push_cost(0, 0); push_cost(32'sh8000_0000, 0); push_cost(32'sh7FFF_FFFF, 0);
    push_cost(-5, 0); push_cost(-5, 0); push_cost(32'sh7FFF_FFFF, 0); push_cost(7, 1);
    wait_drained();

    write_reg(CFG_REFERENCE_FRAME, FRAME_W'(1151));
    push_cost(0, 0); push_cost(-1, 1);
    wait_drained();

    write_reg(CFG_REFERENCE_FRAME, FRAME_W'(2));
    push_cost(3, 0); push_cost(2, 0); push_cost(1, 0); push_cost(0, 0); push_cost(-1, 1);
    wait_drained();
    directed_items = items_queued;

    for (phase = 0; items_queued < directed_items + 180; phase++) begin
      if (items_queued > directed_items + 140) idle_on <= 1'b0;
      if (phase == 3) n = 134;
      else if ($urandom_range(0, 11) == 0) n = $urandom_range(1, 4);
      else n = $urandom_range(5, 40);
      stored = (n > DEPTH) ? DEPTH : n;
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 7) == 0 || stored < 5) r = $urandom_range(0, stored + 2);
        else r = $urandom_range(2, stored - 3);
        lo = (r < 2) ? 2 - r : 0;
        hi = (1151 - r < 1023) ? 1151 - r : 1023;
        case ($urandom_range(0, 5))
          0: skip = lo;
          1: skip = hi;
          default: skip = $urandom_range(lo, hi);
        endcase
        write_reg(CFG_SKIP_COUNT, FRAME_W'(skip));
        write_reg(CFG_REFERENCE_FRAME, FRAME_W'(skip + r));
      end
      if (phase == 1) hold_armed <= 1'b1;
      reps = (phase == 1) ? 3 : $urandom_range(1, 2);
      for (k = 0; k < reps; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: queue_profile(k == 0 ? n : $urandom_range(5, 40), PROFILE_VALLEYS);
          4, 5, 6:    queue_profile(k == 0 ? n : $urandom_range(5, 40), PROFILE_NOISE);
          7, 8:       queue_profile(k == 0 ? n : $urandom_range(5, 40), PROFILE_TIES);
          default:    queue_profile(k == 0 ? n : $urandom_range(5, 40), PROFILE_EXTREMES);
        endcase
      end
      wait_drained();
    end

    repeat (1000) @(negedge clk_i);
    if (errors == 0 && frames_due.size() == 0) begin
      $display("tb_periodic_local_minimum_picker: done, clean");
    end else begin
      $display("tb_periodic_local_minimum_picker: done, errors");
    end
    $finish;
  end

endmodule

// File: periodic_local_minimum_picker.f
src/plmp_pkg.sv
src/plmp_ram.sv
src/periodic_local_minimum_picker.sv
bench/tb_periodic_local_minimum_picker.sv
